// File: rtl/bcs_pkg.sv
// ----------------------------------------------------------------------------
// bcs_pkg: battery charge supervisor shared definitions
// field widths, code enums, register indexes, reset values and bundle types
// ----------------------------------------------------------------------------
package bcs_pkg;

	localparam int OP_W      = 2;
	localparam int CABLE_W   = 2;
	localparam int TEMP_W    = 11;
	localparam int MV_W      = 13;
	localparam int LEVEL_W   = 7;
	localparam int TIME_W    = 32;
	localparam int LIM_W     = 17;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 17;

	localparam logic [LEVEL_W-1:0] LEVEL_MAX = 7'd100;

	// register reset values
	localparam logic signed [TEMP_W-1:0] HOT_BLOCK_RST     = 11'sd600;
	localparam logic signed [TEMP_W-1:0] HOT_RECOVER_RST   = 11'sd400;
	localparam logic signed [TEMP_W-1:0] COLD_RECOVER_RST  = 11'sd0;
	localparam logic signed [TEMP_W-1:0] COLD_BLOCK_RST    = -11'sd50;
	localparam logic [MV_W-1:0]          RECHARGE_MV_RST   = 13'd4130;
	localparam logic [LIM_W-1:0]         CHARGE_LIM_RST    = 17'd21600;
	localparam logic [LIM_W-1:0]         RECHARGE_LIM_RST  = 17'd5400;

	typedef enum logic [OP_W-1:0] {
		OP_POLL  = 2'd0,
		OP_CABLE = 2'd1,
		OP_FULL  = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		ST_DISCHARGING  = 2'd0,
		ST_CHARGING     = 2'd1,
		ST_NOT_CHARGING = 2'd2,
		ST_FULL         = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		H_GOOD     = 2'd0,
		H_OVERHEAT = 2'd1,
		H_COLD     = 2'd2,
		H_FAILURE  = 2'd3
	} health_t;

	typedef enum logic [2:0] {
		F_NONE      = 3'd0,
		F_REAL_FULL = 3'd1,
		F_TIMEOUT   = 3'd2,
		F_TEMP      = 3'd3,
		F_JIG       = 3'd4
	} fault_t;

	typedef enum logic [CABLE_W-1:0] {
		CABLE_NONE = 2'd0,
		CABLE_USB  = 2'd1,
		CABLE_AC   = 2'd2
	} cable_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_HOT_BLOCK     = 3'd0,
		CFG_HOT_RECOVER   = 3'd1,
		CFG_COLD_RECOVER  = 3'd2,
		CFG_COLD_BLOCK    = 3'd3,
		CFG_RECHARGE_MV   = 3'd4,
		CFG_CHARGE_LIM    = 3'd5,
		CFG_RECHARGE_LIM  = 3'd6
	} cfg_idx_t;

	typedef struct packed {
		logic [OP_W-1:0]          operation;
		logic [CABLE_W-1:0]       cable_kind_in;
		logic                     battery_present;
		logic                     jig_attached;
		logic signed [TEMP_W-1:0] temperature;
		logic [MV_W-1:0]          cell_millivolts;
		logic [LEVEL_W-1:0]       charge_level;
		logic [TIME_W-1:0]        now_seconds;
	} item_t;

	typedef struct packed {
		logic signed [TEMP_W-1:0] hot_block_temp;
		logic signed [TEMP_W-1:0] hot_recover_temp;
		logic signed [TEMP_W-1:0] cold_recover_temp;
		logic signed [TEMP_W-1:0] cold_block_temp;
		logic [MV_W-1:0]          recharge_millivolts;
		logic [LIM_W-1:0]         charge_limit_seconds;
		logic [LIM_W-1:0]         recharge_limit_seconds;
	} cfg_t;

	typedef struct packed {
		status_t charge_state;
		health_t health;
		fault_t  fault_cause;
		logic    charger_on;
		logic    usb_online;
		logic    ac_online;
		logic    ac_current_select;
		logic    report_change;
	} result_t;

endpackage

// File: rtl/bcs_if.sv
// ----------------------------------------------------------------------------
// bcs channel interfaces
// event, result and register write channels, valid/ready handshake
// ----------------------------------------------------------------------------
interface bcs_item_if;
	logic                              valid;
	logic                              ready;
	logic [bcs_pkg::OP_W-1:0]          operation;
	logic [bcs_pkg::CABLE_W-1:0]       cable_kind_in;
	logic                              battery_present;
	logic                              jig_attached;
	logic signed [bcs_pkg::TEMP_W-1:0] temperature;
	logic [bcs_pkg::MV_W-1:0]          cell_millivolts;
	logic [bcs_pkg::LEVEL_W-1:0]       charge_level;
	logic [bcs_pkg::TIME_W-1:0]        now_seconds;

	modport source (
		output valid, operation, cable_kind_in, battery_present, jig_attached,
		output temperature, cell_millivolts, charge_level, now_seconds,
		input  ready
	);
	modport sink (
		input  valid, operation, cable_kind_in, battery_present, jig_attached,
		input  temperature, cell_millivolts, charge_level, now_seconds,
		output ready
	);
endinterface

interface bcs_result_if;
	logic       valid;
	logic       ready;
	logic [1:0] charge_state;
	logic [1:0] health;
	logic [2:0] fault_cause;
	logic       charger_on;
	logic       usb_online;
	logic       ac_online;
	logic       ac_current_select;
	logic       report_change;

	modport source (
		output valid, charge_state, health, fault_cause, charger_on,
		output usb_online, ac_online, ac_current_select, report_change,
		input  ready
	);
	modport sink (
		input  valid, charge_state, health, fault_cause, charger_on,
		input  usb_online, ac_online, ac_current_select, report_change,
		output ready
	);
endinterface

interface bcs_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [bcs_pkg::CFG_IDX_W-1:0]    index;
	logic [bcs_pkg::CFG_DAT_W-1:0]    data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// File: rtl/bcs_cfg_regs.sv
// ----------------------------------------------------------------------------
// bcs_cfg_regs: threshold and limit registers
// written one register per write beat, unknown indexes ignored
// ----------------------------------------------------------------------------
module bcs_cfg_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          wr_valid,
	input  logic [bcs_pkg::CFG_IDX_W-1:0] wr_index,
	input  logic [bcs_pkg::CFG_DAT_W-1:0] wr_data,
	output bcs_pkg::cfg_t                 cfg_q
);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.hot_block_temp         <= bcs_pkg::HOT_BLOCK_RST;
			cfg_q.hot_recover_temp       <= bcs_pkg::HOT_RECOVER_RST;
			cfg_q.cold_recover_temp      <= bcs_pkg::COLD_RECOVER_RST;
			cfg_q.cold_block_temp        <= bcs_pkg::COLD_BLOCK_RST;
			cfg_q.recharge_millivolts    <= bcs_pkg::RECHARGE_MV_RST;
			cfg_q.charge_limit_seconds   <= bcs_pkg::CHARGE_LIM_RST;
			cfg_q.recharge_limit_seconds <= bcs_pkg::RECHARGE_LIM_RST;
		end else if (wr_valid) begin
			case (bcs_pkg::cfg_idx_t'(wr_index))
				bcs_pkg::CFG_HOT_BLOCK: begin
					cfg_q.hot_block_temp <= wr_data[bcs_pkg::TEMP_W-1:0];
				end
				bcs_pkg::CFG_HOT_RECOVER: begin
					cfg_q.hot_recover_temp <= wr_data[bcs_pkg::TEMP_W-1:0];
				end
				bcs_pkg::CFG_COLD_RECOVER: begin
					cfg_q.cold_recover_temp <= wr_data[bcs_pkg::TEMP_W-1:0];
				end
				bcs_pkg::CFG_COLD_BLOCK: begin
					cfg_q.cold_block_temp <= wr_data[bcs_pkg::TEMP_W-1:0];
				end
				bcs_pkg::CFG_RECHARGE_MV: begin
					cfg_q.recharge_millivolts <= wr_data[bcs_pkg::MV_W-1:0];
				end
				bcs_pkg::CFG_CHARGE_LIM: begin
					cfg_q.charge_limit_seconds <= wr_data[bcs_pkg::LIM_W-1:0];
				end
				bcs_pkg::CFG_RECHARGE_LIM: begin
					cfg_q.recharge_limit_seconds <= wr_data[bcs_pkg::LIM_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

endmodule

// File: rtl/bcs_in_reg.sv
// ----------------------------------------------------------------------------
// bcs_in_reg: event input register
// holds one accepted event until the update stage takes it
// ----------------------------------------------------------------------------
module bcs_in_reg (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  bcs_pkg::item_t in_item,
	input  logic           advance,
	output logic           in_ready,
	output logic           valid_s1,
	output bcs_pkg::item_t item_s1
);

	// free when empty or when the held event moves on this cycle
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_item;
		end
	end

endmodule

// File: rtl/bcs_engine.sv
// ----------------------------------------------------------------------------
// bcs_engine: supervisor state and combinational update
// applies one event to the charge state and presents the state after it
// ----------------------------------------------------------------------------
module bcs_engine (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             fire,
	input  bcs_pkg::item_t   item,
	input  bcs_pkg::cfg_t    cfg,
	output bcs_pkg::result_t result
);

	bcs_pkg::status_t              status_q, status_d;
	bcs_pkg::health_t              health_q, health_d, health_temp;
	bcs_pkg::fault_t               fault_q, fault_d;
	bcs_pkg::cable_t               cable_q, cable_d;
	logic                          once_full_q, once_full_d;
	logic                          full_step_q, full_step_d;
	logic [bcs_pkg::TIME_W-1:0]    deadline_q, deadline_d;
	logic                          enable_q, enable_d;
	logic [bcs_pkg::LEVEL_W-1:0]   last_level_q, last_level_d;

	logic signed [bcs_pkg::TEMP_W-1:0] temp;
	logic [bcs_pkg::LEVEL_W-1:0]   level_sat;
	logic                          good_band;
	logic                          expired;
	logic                          bad_temp;
	logic                          change_d;
	logic [bcs_pkg::LIM_W-1:0]     limit;
	logic [bcs_pkg::TIME_W:0]      deadline_sum;
	logic [bcs_pkg::TIME_W-1:0]    deadline_arm;

	assign temp      = $signed(item.temperature);
	assign level_sat = (item.charge_level > bcs_pkg::LEVEL_MAX) ? bcs_pkg::LEVEL_MAX
	                                                            : item.charge_level;
	assign good_band = (temp <= $signed(cfg.hot_recover_temp)) &&
	                   (temp >= $signed(cfg.cold_recover_temp));
	assign expired   = (deadline_q != '0) && (item.now_seconds > deadline_q);

	// temperature health with hysteresis, holds between the bands
	always_comb begin
		if (temp >= $signed(cfg.hot_block_temp)) begin
			health_temp = bcs_pkg::H_OVERHEAT;
		end else if (good_band) begin
			health_temp = bcs_pkg::H_GOOD;
		end else if (temp <= $signed(cfg.cold_block_temp)) begin
			health_temp = bcs_pkg::H_COLD;
		end else begin
			health_temp = health_q;
		end
	end

	// once-full only rises on a timeout or a full report, neither of which arms, so the old flag picks the limit
	assign limit        = once_full_q ? cfg.recharge_limit_seconds : cfg.charge_limit_seconds;
	assign deadline_sum = {1'b0, item.now_seconds} +
	                      {{(bcs_pkg::TIME_W + 1 - bcs_pkg::LIM_W){1'b0}}, limit};
	assign deadline_arm = deadline_sum[bcs_pkg::TIME_W] ? '1
	                                                    : deadline_sum[bcs_pkg::TIME_W-1:0];

	always_comb begin
		status_d     = status_q;
		health_d     = health_q;
		fault_d      = fault_q;
		cable_d      = cable_q;
		once_full_d  = once_full_q;
		full_step_d  = full_step_q;
		deadline_d   = deadline_q;
		enable_d     = enable_q;
		last_level_d = last_level_q;
		bad_temp     = 1'b0;
		change_d     = 1'b0;
		case (bcs_pkg::op_t'(item.operation))
			bcs_pkg::OP_POLL: begin
				last_level_d = level_sat;
				health_d     = health_temp;
				if (cable_q != bcs_pkg::CABLE_NONE) begin
					if (!item.battery_present && item.jig_attached) begin
						health_d = bcs_pkg::H_FAILURE;
						status_d = bcs_pkg::ST_NOT_CHARGING;
						fault_d  = bcs_pkg::F_JIG;
					end
					bad_temp = (health_d == bcs_pkg::H_OVERHEAT) ||
					           (health_d == bcs_pkg::H_COLD);
					case (status_d)
						bcs_pkg::ST_CHARGING: begin
							if (expired && level_sat == bcs_pkg::LEVEL_MAX) begin
								once_full_d = 1'b1;
								status_d    = bcs_pkg::ST_FULL;
								fault_d     = bcs_pkg::F_TIMEOUT;
							end else if (bad_temp) begin
								status_d = bcs_pkg::ST_NOT_CHARGING;
								fault_d  = bcs_pkg::F_TEMP;
							end else if (full_step_q) begin
								status_d = bcs_pkg::ST_FULL;
							end
						end
						bcs_pkg::ST_NOT_CHARGING: begin
							if (good_band && health_d != bcs_pkg::H_FAILURE) begin
								fault_d  = bcs_pkg::F_NONE;
								status_d = bcs_pkg::ST_CHARGING;
							end
						end
						bcs_pkg::ST_FULL: begin
							if (item.cell_millivolts < cfg.recharge_millivolts) begin
								fault_d = bcs_pkg::F_NONE;
							end else if (expired) begin
								fault_d = bcs_pkg::F_TIMEOUT;
							end else if (bad_temp) begin
								status_d = bcs_pkg::ST_NOT_CHARGING;
								fault_d  = bcs_pkg::F_TEMP;
							end
						end
						default: begin
						end
					endcase
					if (fault_d == bcs_pkg::F_NONE) begin
						enable_d = 1'b1;
						if (deadline_q == '0) begin
							deadline_d = deadline_arm;
						end
					end else begin
						enable_d   = 1'b0;
						deadline_d = '0;
					end
				end
				change_d = (level_sat != last_level_q) || (status_d != status_q) ||
				           (level_sat == '0);
			end
			bcs_pkg::OP_CABLE: begin
				// unknown cable code counts as unplugged
				if (item.cable_kind_in == bcs_pkg::CABLE_USB ||
				    item.cable_kind_in == bcs_pkg::CABLE_AC) begin
					cable_d = bcs_pkg::cable_t'(item.cable_kind_in);
				end else begin
					cable_d = bcs_pkg::CABLE_NONE;
				end
				if (item.battery_present && cable_d != bcs_pkg::CABLE_NONE) begin
					status_d = bcs_pkg::ST_CHARGING;
				end else begin
					status_d = bcs_pkg::ST_DISCHARGING;
				end
				if (cable_d == bcs_pkg::CABLE_NONE) begin
					once_full_d = 1'b0;
					deadline_d  = '0;
					fault_d     = bcs_pkg::F_NONE;
					full_step_d = 1'b0;
				end
			end
			bcs_pkg::OP_FULL: begin
				once_full_d = 1'b1;
				fault_d     = bcs_pkg::F_REAL_FULL;
				enable_d    = 1'b0;
				full_step_d = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			status_q     <= bcs_pkg::ST_DISCHARGING;
			health_q     <= bcs_pkg::H_GOOD;
			fault_q      <= bcs_pkg::F_NONE;
			cable_q      <= bcs_pkg::CABLE_NONE;
			once_full_q  <= 1'b0;
			full_step_q  <= 1'b0;
			deadline_q   <= '0;
			enable_q     <= 1'b0;
			last_level_q <= '0;
		end else if (fire) begin
			status_q     <= status_d;
			health_q     <= health_d;
			fault_q      <= fault_d;
			cable_q      <= cable_d;
			once_full_q  <= once_full_d;
			full_step_q  <= full_step_d;
			deadline_q   <= deadline_d;
			enable_q     <= enable_d;
			last_level_q <= last_level_d;
		end
	end

	always_comb begin
		result.charge_state      = status_d;
		result.health            = health_d;
		result.fault_cause       = fault_d;
		result.charger_on        = enable_d;
		result.usb_online        = (cable_d == bcs_pkg::CABLE_USB);
		result.ac_online         = (cable_d == bcs_pkg::CABLE_AC);
		result.ac_current_select = (cable_d == bcs_pkg::CABLE_AC);
		result.report_change     = change_d;
	end

endmodule

// File: rtl/battery_charge_supervisor.sv
// ----------------------------------------------------------------------------
// battery_charge_supervisor: charge status, health and charger enable control
//
// item_in takes one event per beat: a poll with measurements, a cable change
// or a full-charge report. result_out gives exactly one result beat per event,
// showing status, health, fault cause, charger enable and cable flags after it.
// cfg writes the thresholds and limits, one register per beat, and is always
// ready; the user makes writes while no event is in flight, not enforced here.
// path: an accepted event is held in the input register, then its result is
// loaded into the result register and offered from there.
// throughput: one event per cycle unless stalled; the whole update is one pass of compare
// and add logic between the input register and the result register, and the
// 32-bit deadline add with its saturation sets the path.
// stall: the result register holds while result_out.ready is low; the input
// register still takes one more event if it was empty, then item_in.ready drops until the
// result is taken.
// reset: arst_n clears both valid flags, puts the state to discharging, good
// health, no fault, no cable, no deadline, and loads the register defaults.
// ----------------------------------------------------------------------------
module battery_charge_supervisor (
	input  logic           clk,
	input  logic           arst_n,
	bcs_item_if.sink       item_in,
	bcs_result_if.source   result_out,
	bcs_cfg_if.sink        cfg
);

	bcs_pkg::cfg_t    cfg_q;
	bcs_pkg::item_t   in_item;
	bcs_pkg::item_t   item_s1;
	bcs_pkg::result_t result;
	bcs_pkg::result_t result_s2;
	logic             valid_s1;
	logic             out_valid_s2;
	logic             out_free;
	logic             advance;

	// register writes never stall
	assign cfg.ready = 1'b1;

	bcs_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (cfg.valid),
		.wr_index (cfg.index),
		.wr_data  (cfg.data),
		.cfg_q    (cfg_q)
	);

	// gather the event beat into one bundle
	always_comb begin
		in_item.operation       = item_in.operation;
		in_item.cable_kind_in   = item_in.cable_kind_in;
		in_item.battery_present = item_in.battery_present;
		in_item.jig_attached    = item_in.jig_attached;
		in_item.temperature     = item_in.temperature;
		in_item.cell_millivolts = item_in.cell_millivolts;
		in_item.charge_level    = item_in.charge_level;
		in_item.now_seconds     = item_in.now_seconds;
	end

	// result register is free when empty or being drained
	assign out_free = !out_valid_s2 || result_out.ready;
	assign advance  = valid_s1 && out_free;

	bcs_in_reg u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (item_in.valid),
		.in_item  (in_item),
		.advance  (advance),
		.in_ready (item_in.ready),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	// state commits in the same edge that loads the result register
	bcs_engine u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (advance),
		.item   (item_s1),
		.cfg    (cfg_q),
		.result (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (out_free) begin
			out_valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= result;
		end
	end

	// result beat
	assign result_out.valid             = out_valid_s2;
	assign result_out.charge_state      = result_s2.charge_state;
	assign result_out.health            = result_s2.health;
	assign result_out.fault_cause       = result_s2.fault_cause;
	assign result_out.charger_on        = result_s2.charger_on;
	assign result_out.usb_online        = result_s2.usb_online;
	assign result_out.ac_online         = result_s2.ac_online;
	assign result_out.ac_current_select = result_s2.ac_current_select;
	assign result_out.report_change     = result_s2.report_change;

	// a cable is never both usb and ac
	a_cable_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_s2 |-> !(result_s2.usb_online && result_s2.ac_online))
		else $error("usb and ac both online");

	// charger only runs while no fault is recorded
	a_enable_no_fault: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_s2 && result_s2.charger_on) |-> (result_s2.fault_cause == bcs_pkg::F_NONE))
		else $error("charger on with a fault recorded");

	// an event that moves on always shows up as a result beat next cycle
	a_advance_lands: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid_s2)
		else $error("advanced event lost before the result register");

	// a stalled result beat must not be overwritten
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_s2 && !result_out.ready) |=> $stable(result_s2))
		else $error("result register changed while stalled");

endmodule

// File: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: battery charge supervisor testbench
// drives cable, poll and full-charge events into the block, predicts every
// result beat with an in-bench copy of the supervisor, and checks each beat
// field by field; thresholds and limits are rewritten between traffic phases
// ----------------------------------------------------------------------------
module tb_top;
	import bcs_pkg::*;

	// codes the package has no name for, used to hit the unknown-value cases
	localparam logic [OP_W-1:0]    OP_UNKNOWN    = 2'd3;
	localparam logic [CABLE_W-1:0] CABLE_UNKNOWN = 2'd3;

	logic clk;
	logic arst_n;

	bcs_item_if   item_bus ();
	bcs_result_if res_bus ();
	bcs_cfg_if    cfg_bus ();

	battery_charge_supervisor DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_in    (item_bus),
		.result_out (res_bus),
		.cfg        (cfg_bus)
	);

	// expected result beats, oldest first
	result_t pending_reports[$];
	int unsigned mismatches = 0;

	// idle and stall switches; both go off for the last phase
	bit idle_on  = 1'b1;
	bit stall_on = 1'b1;
	int unsigned stall_left = 0;

	// running wall clock used for poll timestamps
	logic [TIME_W-1:0] sim_now = '0;

	// supervisor state as the bench sees it
	status_t           chg_status;
	health_t           batt_health;
	fault_t            fault_now;
	cable_t            cable_now;
	logic              once_full;
	logic              full_seen;
	logic [TIME_W-1:0] deadline;
	logic              chg_enable;
	logic [LEVEL_W-1:0] level_prev;

	// threshold and limit registers as the bench sees them
	logic signed [TEMP_W-1:0] hot_block;
	logic signed [TEMP_W-1:0] hot_recover;
	logic signed [TEMP_W-1:0] cold_recover;
	logic signed [TEMP_W-1:0] cold_block;
	logic [MV_W-1:0]          recharge_mv;
	logic [LIM_W-1:0]         charge_lim;
	logic [LIM_W-1:0]         recharge_lim;

	// free-running clock, period 8
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// hard stop in case the block hangs a handshake
	initial begin
		#4000000;
		$display("TB_ERROR");
		$finish;
	end

	// result side back-pressure: random stall bursts
	initial begin
		res_bus.ready = 1'b1;
		forever begin
			@(negedge clk);
			if (stall_on && stall_left == 0 && $urandom_range(0, 4) == 0) begin
				stall_left = $urandom_range(1, 5);
			end
			if (stall_left != 0) begin
				res_bus.ready = 1'b0;
				stall_left--;
			end else begin
				res_bus.ready = 1'b1;
			end
		end
	end

	// one event in, one status report out: updates the bench copy of the state
	function automatic result_t advance_supervisor(item_t ev);
		result_t            r;
		status_t            status_before;
		logic [LEVEL_W-1:0] prev_level;
		logic [LEVEL_W-1:0] level;
		logic signed [TEMP_W-1:0] t;
		logic               expired;
		logic               good_band;
		logic               bad_temp;
		logic               report;
		logic [TIME_W:0]    sum;
		report = 1'b0;
		case (ev.operation)
			OP_POLL: begin
				status_before = chg_status;
				prev_level  = level_prev;
				level       = (ev.charge_level > LEVEL_MAX) ? LEVEL_MAX : ev.charge_level;
				level_prev  = level;
				t           = ev.temperature;
				expired     = (deadline != '0) && (ev.now_seconds > deadline);
				good_band   = (t <= hot_recover) && (t >= cold_recover);
				// health hysteresis; between the bands health holds
				if (t >= hot_block) begin
					batt_health = H_OVERHEAT;
				end else if (good_band) begin
					batt_health = H_GOOD;
				end else if (t <= cold_block) begin
					batt_health = H_COLD;
				end
				// without a cable only health and level move
				if (cable_now != CABLE_NONE) begin
					if (!ev.battery_present && ev.jig_attached) begin
						batt_health = H_FAILURE;
						chg_status  = ST_NOT_CHARGING;
						fault_now   = F_JIG;
					end
					bad_temp = (batt_health == H_OVERHEAT) || (batt_health == H_COLD);
					case (chg_status)
						ST_CHARGING: begin
							if (expired && level_prev == LEVEL_MAX) begin
								once_full  = 1'b1;
								chg_status = ST_FULL;
								fault_now  = F_TIMEOUT;
							end else if (bad_temp) begin
								chg_status = ST_NOT_CHARGING;
								fault_now  = F_TEMP;
							end else if (full_seen) begin
								chg_status = ST_FULL;
							end
						end
						ST_NOT_CHARGING: begin
							if (good_band && batt_health != H_FAILURE) begin
								fault_now  = F_NONE;
								chg_status = ST_CHARGING;
							end
						end
						ST_FULL: begin
							if (ev.cell_millivolts < recharge_mv) begin
								fault_now = F_NONE;
							end else if (expired) begin
								fault_now = F_TIMEOUT;
							end else if (bad_temp) begin
								chg_status = ST_NOT_CHARGING;
								fault_now  = F_TEMP;
							end
						end
						default: ;
					endcase
					// no fault: charger on and deadline armed once, saturating
					if (fault_now == F_NONE) begin
						chg_enable = 1'b1;
						if (deadline == '0) begin
							sum = {1'b0, ev.now_seconds} +
								(TIME_W + 1)'(once_full ? recharge_lim : charge_lim);
							deadline = sum[TIME_W] ? '1 : sum[TIME_W-1:0];
						end
					end else begin
						chg_enable = 1'b0;
						deadline   = '0;
					end
				end
				report = (level != prev_level) || (chg_status != status_before) ||
					(level == '0);
			end
			OP_CABLE: begin
				cable_now = (ev.cable_kind_in > CABLE_AC) ? CABLE_NONE : cable_t'(ev.cable_kind_in);
				chg_status = (ev.battery_present && cable_now != CABLE_NONE) ?
					ST_CHARGING : ST_DISCHARGING;
				if (cable_now == CABLE_NONE) begin
					once_full = 1'b0;
					deadline  = '0;
					fault_now = F_NONE;
					full_seen = 1'b0;
				end
			end
			OP_FULL: begin
				once_full  = 1'b1;
				fault_now  = F_REAL_FULL;
				chg_enable = 1'b0;
				full_seen  = 1'b1;
			end
			default: ; // unknown operation leaves everything alone
		endcase
		r.charge_state      = chg_status;
		r.health            = batt_health;
		r.fault_cause       = fault_now;
		r.charger_on        = chg_enable;
		r.usb_online        = (cable_now == CABLE_USB);
		r.ac_online         = (cable_now == CABLE_AC);
		r.ac_current_select = (cable_now == CABLE_AC);
		r.report_change     = report;
		return r;
	endfunction

	function automatic item_t make_event(logic [OP_W-1:0] op, logic [CABLE_W-1:0] kind,
			int present, int jig, int temp, int mv, int level, logic [TIME_W-1:0] now);
		item_t ev;
		ev.operation       = op;
		ev.cable_kind_in   = kind;
		ev.battery_present = 1'(present);
		ev.jig_attached    = 1'(jig);
		ev.temperature     = TEMP_W'(temp);
		ev.cell_millivolts = MV_W'(mv);
		ev.charge_level    = LEVEL_W'(level);
		ev.now_seconds     = now;
		return ev;
	endfunction

	// temperatures cluster around the four thresholds, with some wild values
	function automatic logic signed [TEMP_W-1:0] pick_temp();
		int base;
		case ($urandom_range(0, 9))
			0: return TEMP_W'($urandom);
			1, 2: base = hot_block;
			3, 4: base = hot_recover;
			5, 6: base = cold_recover;
			7, 8: base = cold_block;
			default: base = int'($urandom_range(0, 1500)) - 500;
		endcase
		return TEMP_W'(base + int'($urandom_range(0, 4)) - 2);
	endfunction

	// mostly polls with moving time, levels near full and voltages near recharge
	function automatic item_t random_event();
		item_t ev;
		int unsigned sel;
		int unsigned k;
		ev.operation       = OP_POLL;
		ev.cable_kind_in   = CABLE_W'($urandom_range(0, 3));
		ev.battery_present = ($urandom_range(0, 9) != 0);
		ev.jig_attached    = ($urandom_range(0, 9) == 0);
		ev.temperature     = pick_temp();
		ev.cell_millivolts = ($urandom_range(0, 3) == 0) ? MV_W'($urandom) :
			MV_W'(int'(recharge_mv) + int'($urandom_range(0, 4)) - 2);
		case ($urandom_range(0, 19))
			0, 1: ev.charge_level = LEVEL_W'($urandom_range(0, 127));
			2, 3, 4: ev.charge_level = LEVEL_W'($urandom_range(0, 100));
			5, 6, 7, 8, 9: ev.charge_level = LEVEL_W'($urandom_range(95, 100));
			default: ev.charge_level = LEVEL_MAX;
		endcase
		// wall clock steps: short, long, very long, or a jump anywhere
		k = $urandom_range(0, 99);
		if (k < 70) begin
			sim_now += $urandom_range(0, 600);
		end else if (k < 90) begin
			sim_now += $urandom_range(0, 40000);
		end else if (k < 97) begin
			sim_now += $urandom_range(100000, 200000);
		end else begin
			sim_now = $urandom;
		end
		ev.now_seconds = sim_now;
		sel = $urandom_range(0, 99);
		if (sel < 8) begin
			ev.operation = OP_CABLE;
			k = $urandom_range(0, 19);
			if (k < 4) begin
				ev.cable_kind_in = CABLE_NONE;
			end else if (k == 4) begin
				ev.cable_kind_in = CABLE_UNKNOWN;
			end else begin
				ev.cable_kind_in = k[0] ? CABLE_USB : CABLE_AC;
			end
		end else if (sel < 12) begin
			ev.operation = OP_FULL;
		end else if (sel < 15) begin
			// noise: unknown operation with junk payload
			ev.operation   = OP_UNKNOWN;
			ev.temperature = TEMP_W'($urandom);
			ev.now_seconds = $urandom;
		end
		return ev;
	endfunction

	task automatic compare_field(string what, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
			mismatches++;
		end
	endtask

	// result checker: every accepted beat against the oldest expectation
	result_t report_want;
	always @(posedge clk) begin
		if (arst_n && res_bus.valid && res_bus.ready) begin
			if (pending_reports.size() == 0) begin
				$display("%0t: result beat with nothing expected", $time);
				mismatches++;
			end else begin
				report_want = pending_reports.pop_front();
				compare_field("charge_state", 32'(report_want.charge_state),
					32'(res_bus.charge_state));
				compare_field("health", 32'(report_want.health), 32'(res_bus.health));
				compare_field("fault_cause", 32'(report_want.fault_cause),
					32'(res_bus.fault_cause));
				compare_field("charger_on", 32'(report_want.charger_on),
					32'(res_bus.charger_on));
				compare_field("usb_online", 32'(report_want.usb_online),
					32'(res_bus.usb_online));
				compare_field("ac_online", 32'(report_want.ac_online),
					32'(res_bus.ac_online));
				compare_field("ac_current_select", 32'(report_want.ac_current_select),
					32'(res_bus.ac_current_select));
				compare_field("report_change", 32'(report_want.report_change),
					32'(res_bus.report_change));
			end
		end
	end

	// send one event beat; valid stays high so back-to-back beats need no drop
	task automatic send_event(item_t ev);
		int unsigned gap;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 5);
			@(negedge clk);
			item_bus.valid = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		item_bus.operation       = ev.operation;
		item_bus.cable_kind_in   = ev.cable_kind_in;
		item_bus.battery_present = ev.battery_present;
		item_bus.jig_attached    = ev.jig_attached;
		item_bus.temperature     = ev.temperature;
		item_bus.cell_millivolts = ev.cell_millivolts;
		item_bus.charge_level    = ev.charge_level;
		item_bus.now_seconds     = ev.now_seconds;
		item_bus.valid           = 1'b1;
		do @(posedge clk); while (!item_bus.ready);
		pending_reports.push_back(advance_supervisor(ev));
	endtask

	// stop sending and let every outstanding report come back
	task automatic wait_for_results();
		@(negedge clk);
		item_bus.valid = 1'b0;
		while (pending_reports.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(cfg_idx_t idx, logic [CFG_DAT_W-1:0] value);
		@(negedge clk);
		cfg_bus.index = idx;
		cfg_bus.data  = value;
		cfg_bus.valid = 1'b1;
		do @(posedge clk); while (!cfg_bus.ready);
		case (idx)
			CFG_HOT_BLOCK:    hot_block    = value[TEMP_W-1:0];
			CFG_HOT_RECOVER:  hot_recover  = value[TEMP_W-1:0];
			CFG_COLD_RECOVER: cold_recover = value[TEMP_W-1:0];
			CFG_COLD_BLOCK:   cold_block   = value[TEMP_W-1:0];
			CFG_RECHARGE_MV:  recharge_mv  = value[MV_W-1:0];
			CFG_CHARGE_LIM:   charge_lim   = value[LIM_W-1:0];
			CFG_RECHARGE_LIM: recharge_lim = value[LIM_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_bus.valid = 1'b0;
	endtask

	// full register set, only with the block drained
	task automatic set_thresholds(int hb, int hr, int cr, int cb, int unsigned mv,
			int unsigned cl, int unsigned rl);
		wait_for_results();
		write_reg(CFG_HOT_BLOCK, CFG_DAT_W'(hb));
		write_reg(CFG_HOT_RECOVER, CFG_DAT_W'(hr));
		write_reg(CFG_COLD_RECOVER, CFG_DAT_W'(cr));
		write_reg(CFG_COLD_BLOCK, CFG_DAT_W'(cb));
		write_reg(CFG_RECHARGE_MV, CFG_DAT_W'(mv));
		write_reg(CFG_CHARGE_LIM, CFG_DAT_W'(cl));
		write_reg(CFG_RECHARGE_LIM, CFG_DAT_W'(rl));
	endtask

	// walk the charge cycle by hand at the reset thresholds
	task automatic test_directed_events();
		// unknown operation with every payload bit set
		send_event(make_event(OP_UNKNOWN, CABLE_UNKNOWN, 1, 1, -1, 8191, 127, '1));
		// polls with no cable: health only, extremes of temperature and level
		send_event(make_event(OP_POLL, CABLE_NONE, 1, 0, -1024, 0, 0, 0));
		send_event(make_event(OP_POLL, CABLE_NONE, 1, 0, 1023, 0, 127, 0));
		send_event(make_event(OP_POLL, CABLE_NONE, 1, 0, 500, 100, 60, 10));
		// unknown cable kind counts as none
		send_event(make_event(OP_CABLE, CABLE_UNKNOWN, 1, 0, 0, 0, 0, 0));
		send_event(make_event(OP_CABLE, CABLE_USB, 1, 0, 0, 0, 0, 0));
		// start charging, then time out at full level
		send_event(make_event(OP_POLL, CABLE_NONE, 1, 0, 250, 4000, 100, 1000));
		send_event(make_event(OP_POLL, CABLE_NONE, 1, 0, 250, 4000, 100, 30000));
		// recharge voltage restarts, then overheat stops it
		send_event(make_event(OP_POLL, CABLE_NONE, 1, 0, 250, 4000, 100, 30001));
		send_event(make_event(OP_POLL, CABLE_NONE, 1, 0, 1000, 4200, 100, 30002));
		send_event(make_event(OP_POLL, CABLE_NONE, 1, 0, 300, 4200, 100, 30003));
		// charger reports full, next poll goes to full
		send_event(make_event(OP_FULL, CABLE_NONE, 0, 0, 0, 0, 0, 0));
		send_event(make_event(OP_POLL, CABLE_NONE, 1, 0, 300, 4200, 100, 30004));
		// battery pulled with jig attached
		send_event(make_event(OP_POLL, CABLE_NONE, 0, 1, 300, 4200, 100, 30005));
		send_event(make_event(OP_POLL, CABLE_NONE, 1, 0, 300, 4200, 90, 30006));
		// ac without a battery, then cold while discharging
		send_event(make_event(OP_CABLE, CABLE_AC, 0, 0, 0, 0, 0, 0));
		send_event(make_event(OP_POLL, CABLE_NONE, 1, 0, -500, 3000, 50, 30007));
		send_event(make_event(OP_CABLE, CABLE_NONE, 1, 0, 0, 0, 0, 0));
		// deadline near the top of time saturates
		send_event(make_event(OP_CABLE, CABLE_AC, 1, 0, 0, 0, 0, 0));
		send_event(make_event(OP_POLL, CABLE_NONE, 1, 0, 200, 3800, 99, 32'hFFFF_FFF0));
		send_event(make_event(OP_POLL, CABLE_NONE, 1, 0, 200, 3800, 100, '1));
		// between the cold bands and below the cold block
		send_event(make_event(OP_POLL, CABLE_NONE, 1, 0, -20, 3800, 100, '1));
		send_event(make_event(OP_POLL, CABLE_NONE, 1, 0, -100, 3800, 100, '1));
	endtask

	// zero limit leaves no deadline; a later enabling poll arms one
	task automatic test_deadline_edges();
		set_thresholds(HOT_BLOCK_RST, HOT_RECOVER_RST, COLD_RECOVER_RST, COLD_BLOCK_RST,
			RECHARGE_MV_RST, 0, 131071);
		send_event(make_event(OP_CABLE, CABLE_NONE, 1, 0, 0, 0, 0, 0));
		send_event(make_event(OP_CABLE, CABLE_USB, 1, 0, 0, 0, 0, 0));
		send_event(make_event(OP_POLL, CABLE_NONE, 1, 0, 200, 4000, 100, 0));
		send_event(make_event(OP_POLL, CABLE_NONE, 1, 0, 200, 4000, 100, 0));
		send_event(make_event(OP_POLL, CABLE_NONE, 1, 0, 200, 4000, 100, 7));
		send_event(make_event(OP_POLL, CABLE_NONE, 1, 0, 200, 4000, 100, 8));
		send_event(make_event(OP_POLL, CABLE_NONE, 1, 0, 200, 0, 100, 9));
		send_event(make_event(OP_POLL, CABLE_NONE, 1, 0, 200, 5000, 100, 200000));
	endtask

	// random event traffic; drain now and then so the sender waits on the block
	task automatic test_random_traffic(int unsigned count);
		for (int unsigned n = 0; n < count; n++) begin
			if (n != 0 && n % 150 == 0) begin
				wait_for_results();
			end
			send_event(random_event());
		end
	endtask

	task automatic test_ordered_thresholds();
		int cb;
		int cr;
		int hr;
		int hb;
		cb = int'($urandom_range(0, 300)) - 500;
		cr = cb + int'($urandom_range(0, 300));
		hr = cr + int'($urandom_range(0, 400));
		hb = hr + int'($urandom_range(0, 300));
		set_thresholds(hb, hr, cr, cb, $urandom_range(3000, 4500),
			$urandom_range(1, 60000), $urandom_range(1, 20000));
		test_random_traffic(300);
	endtask

	task automatic test_scrambled_thresholds();
		set_thresholds(int'($urandom_range(0, 2047)) - 1024, int'($urandom_range(0, 2047)) - 1024,
			int'($urandom_range(0, 2047)) - 1024, int'($urandom_range(0, 2047)) - 1024,
			$urandom_range(0, 8191), $urandom_range(0, 131071), $urandom_range(0, 131071));
		test_random_traffic(300);
	endtask

	initial begin
		// everything known from time zero while reset is held
		arst_n                   = 1'b0;
		item_bus.valid           = 1'b0;
		item_bus.operation       = OP_POLL;
		item_bus.cable_kind_in   = CABLE_NONE;
		item_bus.battery_present = 1'b0;
		item_bus.jig_attached    = 1'b0;
		item_bus.temperature     = '0;
		item_bus.cell_millivolts = '0;
		item_bus.charge_level    = '0;
		item_bus.now_seconds     = '0;
		cfg_bus.valid            = 1'b0;
		cfg_bus.index            = CFG_HOT_BLOCK;
		cfg_bus.data             = '0;
		chg_status   = ST_DISCHARGING;
		batt_health  = H_GOOD;
		fault_now    = F_NONE;
		cable_now    = CABLE_NONE;
		once_full    = 1'b0;
		full_seen    = 1'b0;
		deadline     = '0;
		chg_enable   = 1'b0;
		level_prev   = '0;
		hot_block    = HOT_BLOCK_RST;
		hot_recover  = HOT_RECOVER_RST;
		cold_recover = COLD_RECOVER_RST;
		cold_block   = COLD_BLOCK_RST;
		recharge_mv  = RECHARGE_MV_RST;
		charge_lim   = CHARGE_LIM_RST;
		recharge_lim = RECHARGE_LIM_RST;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed_events();
		test_deadline_edges();

		// widest good band, top voltage and limits
		set_thresholds(1000, 1000, -500, -500, 8191, 131071, 131071);
		test_random_traffic(300);
		// everything at the bottom: zero limits, no recharge voltage
		set_thresholds(-500, -500, -500, -500, 0, 0, 0);
		test_random_traffic(300);
		test_ordered_thresholds();
		test_scrambled_thresholds();

		// last phase at reset values, no idling on either side
		set_thresholds(HOT_BLOCK_RST, HOT_RECOVER_RST, COLD_RECOVER_RST, COLD_BLOCK_RST,
			RECHARGE_MV_RST, CHARGE_LIM_RST, RECHARGE_LIM_RST);
		idle_on  = 1'b0;
		stall_on = 1'b0;
		test_random_traffic(470);

		// drain, then keep the clock running to catch stray beats
		wait_for_results();
		repeat (8) @(posedge clk);
		if (mismatches == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
